@@ hdl/rwm_pkg.sv @@
// Package for the rolling window mean block: sizes, controller states and
// the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package rwm_pkg;

    // Window and sample sizes
    localparam int MAX_WINDOW   = 64;
    localparam int SAMPLE_BITS  = 16;
    localparam int CFG_W        = 7;
    localparam int SLOT_W       = $clog2(MAX_WINDOW);
    localparam int CNT_W        = $clog2(MAX_WINDOW + 1);
    localparam int SUM_W        = SAMPLE_BITS + SLOT_W;
    localparam int DIV_CNT_W    = $clog2(SUM_W + 1);
    localparam int DATA_W       = ((SAMPLE_BITS + 7) / 8) * 8;

    // Window length after reset
    localparam logic [CFG_W-1:0] WINDOW_RESET = CFG_W'(64);

    // Controller states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_START,
        ST_DIVIDE,
        ST_DONE
    } t_state;

    // Controller to datapath
    typedef struct packed {
        logic load_sample;
        logic update;
        logic div_start;
        logic out_load;
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic div_done;
        logic out_free;
    } t_status;

endpackage

`default_nettype wire

@@ hdl/rolling_window_mean.sv @@
// Simple moving average of signed samples over a configurable window.
//
// Input stream (i_s_*): one signed sample per request. Output stream
// (o_m_*): one result per sample, the mean of the held samples rounded
// toward zero, with a flag telling whether the window is full.
// Config channel (i_cfg_*): writes the window length (0 acts as 1, values
// above 64 act as 64) and empties the window. Write only while idle.
//
// Each sample passes these steps from acceptance to a valid result: the
// accepting edge reads the oldest sample from the ring RAM, then the
// running sum is updated, the divider is loaded and retires the quotient
// bits one at a time, the divider's done flag is registered and the result
// register is loaded. A new sample can be taken the cycle after the result
// load, so no sample is accepted while another is in process. If the
// receiver stalls, the result holds in the output register; the next
// sample is still accepted and processed, and waits before the result
// load until the register frees.
// Reset empties the window and sets the length to 64; ring contents are
// not cleared (only held samples are ever read), so no clearing pass runs.
// Depends on rwm_pkg, rwm_ctrl, rwm_dp.
`default_nettype none

module rolling_window_mean (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    // Sample stream in
    input  wire logic                         i_s_tvalid,
    output logic                              o_s_tready,
    input  wire logic [rwm_pkg::DATA_W-1:0]   i_s_tdata,   // [15:0] sample
    // Mean stream out
    output logic                              o_m_tvalid,
    input  wire logic                         i_m_tready,
    output logic      [rwm_pkg::DATA_W-1:0]   o_m_tdata,   // [15:0] mean
    output logic      [0:0]                   o_m_tuser,   // [0] window_full
    // Window length write channel
    input  wire logic                         i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire logic [rwm_pkg::CFG_W-1:0]    i_cfg_data
);
    import rwm_pkg::*;

    t_cmd                          w_cmd;
    t_status                       w_status;
    logic signed [SAMPLE_BITS-1:0] w_mean;
    logic                          w_window_full;

    // Config writes are always taken
    assign o_cfg_ready = 1'b1;

    rwm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_tvalid),
        .o_in_ready (o_s_tready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    rwm_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .o_status      (w_status),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_data    (i_cfg_data),
        .i_sample      (signed'(i_s_tdata[SAMPLE_BITS-1:0])),
        .i_out_ready   (i_m_tready),
        .o_out_valid   (o_m_tvalid),
        .o_mean        (w_mean),
        .o_window_full (w_window_full)
    );

    // Pack the result fields
    assign o_m_tdata = DATA_W'(unsigned'(w_mean));
    assign o_m_tuser = w_window_full;

`ifndef SYNTH
    // One sample at a time: ready is low right after an accepted sample
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_tvalid && o_s_tready) |=> !o_s_tready)
        else $error("sample accepted while another is in flight");

    // Never overwrite a result the receiver has not taken
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!o_m_tvalid || i_m_tready))
        else $error("result register overwritten");

    // A result appears only after the controller loads one
    a_valid_from_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_m_tvalid) |-> $past(w_cmd.out_load))
        else $error("output valid without a result load");
`endif

endmodule

`default_nettype wire

@@ hdl/rwm_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module rwm_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

@@ hdl/rwm_div.sv @@
// Iterative signed-by-unsigned divider, one quotient bit per cycle,
// quotient rounded toward zero. Depends on rwm_pkg.
`default_nettype none

module rwm_div (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_start,
    input  wire logic signed [rwm_pkg::SUM_W-1:0]    i_dividend,
    input  wire logic        [rwm_pkg::CNT_W-1:0]    i_divisor,
    output logic                                     o_done,
    output logic signed      [rwm_pkg::SUM_W-1:0]    o_quotient
);
    import rwm_pkg::*;

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [DIV_CNT_W-1:0] r_cnt, n_cnt;
    logic [SUM_W-1:0]     r_work, n_work;
    logic [CNT_W-1:0]     r_rem, n_rem;
    logic [CNT_W-1:0]     r_div, n_div;
    logic                 r_neg, n_neg;
    logic [CNT_W:0]       w_shift;
    logic                 w_ge;

    // One restoring step: shift in the next dividend bit, try the subtract
    assign w_shift = {r_rem, r_work[SUM_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_work = r_work;
        n_rem  = r_rem;
        n_div  = r_div;
        n_neg  = r_neg;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(SUM_W);
            n_work = i_dividend[SUM_W-1] ? SUM_W'(-i_dividend) : SUM_W'(i_dividend);
            n_rem  = '0;
            n_div  = i_divisor;
            n_neg  = i_dividend[SUM_W-1];
        end else if (r_busy) begin
            n_work = {r_work[SUM_W-2:0], w_ge};
            n_rem  = w_ge ? CNT_W'(w_shift - {1'b0, r_div}) : CNT_W'(w_shift);
            n_cnt  = r_cnt - DIV_CNT_W'(1);
            if (r_cnt == DIV_CNT_W'(1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    // Operands and partial results
    always_ff @(posedge i_clk) begin
        r_work <= n_work;
        r_rem  <= n_rem;
        r_div  <= n_div;
        r_neg  <= n_neg;
    end

    // Apply the sign to the magnitude quotient
    assign o_done     = r_done;
    assign o_quotient = r_neg ? -signed'(r_work) : signed'(r_work);

endmodule

`default_nettype wire

@@ hdl/rwm_dp.sv @@
// Datapath of the rolling window mean: sample ring, running sum, fill count,
// divider and result register. Depends on rwm_pkg, rwm_ram and rwm_div.
`default_nettype none

module rwm_dp (
    input  wire logic                                   i_clk,
    input  wire logic                                   i_rst_n,
    input  wire rwm_pkg::t_cmd                          i_cmd,
    output rwm_pkg::t_status                            o_status,
    input  wire logic                                   i_cfg_we,
    input  wire logic        [rwm_pkg::CFG_W-1:0]       i_cfg_data,
    input  wire logic signed [rwm_pkg::SAMPLE_BITS-1:0] i_sample,
    input  wire logic                                   i_out_ready,
    output logic                                        o_out_valid,
    output logic signed      [rwm_pkg::SAMPLE_BITS-1:0] o_mean,
    output logic                                        o_window_full
);
    import rwm_pkg::*;

    logic [CFG_W-1:0]              r_window_length;
    logic [SLOT_W-1:0]             r_slot, n_slot;
    logic [CNT_W-1:0]              r_held, n_held;
    logic signed [SUM_W-1:0]       r_sum, n_sum;
    logic                          r_full, n_full;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic                          r_out_valid;
    logic signed [SAMPLE_BITS-1:0] r_mean;
    logic                          r_out_full;

    logic [CNT_W-1:0]              w_len;
    logic                          w_at_len;
    logic [CNT_W:0]                w_back;
    logic [SLOT_W-1:0]             w_old_slot;
    logic [SAMPLE_BITS-1:0]        w_rdata;
    logic signed [SUM_W-1:0]       w_drop;
    logic                          w_div_done;
    logic signed [SUM_W-1:0]       w_quotient;

    // Clamp the window length to 1..MAX_WINDOW
    always_comb begin
        priority if (r_window_length == '0) begin
            w_len = CNT_W'(1);
        end else if (32'(r_window_length) > 32'(MAX_WINDOW)) begin
            w_len = CNT_W'(MAX_WINDOW);
        end else begin
            w_len = CNT_W'(r_window_length);
        end
    end

    assign w_at_len = (r_held >= w_len);

    // Oldest held slot sits window length slots behind the write slot
    always_comb begin
        w_back = (CNT_W+1)'(r_slot) + (CNT_W+1)'(MAX_WINDOW) - (CNT_W+1)'(w_len);
        if (w_back >= (CNT_W+1)'(MAX_WINDOW)) begin
            w_back = w_back - (CNT_W+1)'(MAX_WINDOW);
        end
        w_old_slot = SLOT_W'(w_back);
    end

    rwm_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (MAX_WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (i_cmd.update),
        .i_waddr (r_slot),
        .i_wdata (r_sample),
        .i_raddr (w_old_slot),
        .o_rdata (w_rdata)
    );

    // Drop the oldest sample once the window is full, add the new one
    assign w_drop = w_at_len ? SUM_W'(signed'(w_rdata)) : '0;

    always_comb begin
        n_sum  = r_sum + SUM_W'(r_sample) - w_drop;
        n_held = w_at_len ? w_len : r_held + CNT_W'(1);
        n_full = (n_held == w_len);
        n_slot = (r_slot == SLOT_W'(MAX_WINDOW - 1)) ? '0 : r_slot + SLOT_W'(1);
    end

    // Window state and length register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window_length <= WINDOW_RESET;
            r_slot          <= '0;
            r_held          <= '0;
            r_sum           <= '0;
        end else begin
            priority if (i_cfg_we) begin
                r_window_length <= i_cfg_data;
                r_slot          <= '0;
                r_held          <= '0;
                r_sum           <= '0;
            end else if (i_cmd.update) begin
                r_slot <= n_slot;
                r_held <= n_held;
                r_sum  <= n_sum;
            end
        end
    end

    // Hold the request payload and the full flag of the current item
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_sample) begin
            r_sample <= i_sample;
        end
        if (i_cmd.update) begin
            r_full <= n_full;
        end
    end

    rwm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_sum),
        .i_divisor  (r_held),
        .o_done     (w_div_done),
        .o_quotient (w_quotient)
    );

    // Result register: valid until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_mean     <= SAMPLE_BITS'(w_quotient);
            r_out_full <= r_full;
        end
    end

    assign o_status.div_done = w_div_done;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_mean            = r_mean;
    assign o_window_full     = r_out_full;

endmodule

`default_nettype wire

@@ hdl/rwm_ctrl.sv @@
// Controller of the rolling window mean: sequences accept, sum update,
// divide and result load. Depends on rwm_pkg.
`default_nettype none

module rwm_ctrl (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_in_valid,
    output logic                  o_in_ready,
    input  wire rwm_pkg::t_status i_status,
    output rwm_pkg::t_cmd         o_cmd
);
    import rwm_pkg::*;

    t_state r_state, n_state;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_UPDATE;
                end
            end
            ST_UPDATE: begin
                n_state = ST_START;
            end
            ST_START: begin
                n_state = ST_DIVIDE;
            end
            ST_DIVIDE: begin
                if (i_status.div_done) begin
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
                if (i_status.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Commands
    always_comb begin
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_ready        = 1'b1;
                o_cmd.load_sample = i_in_valid;
            end
            ST_UPDATE: begin
                o_cmd.update = 1'b1;
            end
            ST_START: begin
                o_cmd.div_start = 1'b1;
            end
            ST_DIVIDE: begin
            end
            ST_DONE: begin
                o_cmd.out_load = i_status.out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire
